### src/tccw_pkg.sv
// Shared types and constants for the text console cell writer.
// Holds the item and result structs, the kind and state enums and the default geometry.
// No dependencies; every other source file imports this package.
package tccw_pkg;

  // Default screen geometry and tab width.
  localparam int unsigned DEF_COLUMNS  = 80;
  localparam int unsigned DEF_ROWS     = 25;
  localparam int unsigned DEF_TAB_STEP = 4;

  // Field widths of the stream items.
  localparam int unsigned KIND_W = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned LOC_W  = 11;
  localparam int unsigned CELL_W = 16;

  // Packed stream widths, padded to whole bytes.
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 40;

  // Attribute after reset and the control characters of cooked mode.
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT   = 2'd0,
    KIND_SET   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_READ
  } state_e;

  typedef struct packed {
    kind_e             kind;
    logic [CHAR_W-1:0] char_code;
    logic              raw_mode;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
  } item_t;

  typedef struct packed {
    logic [LOC_W-1:0]  cursor_location;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [CELL_W-1:0] read_data;
    logic              position_error;
  } result_t;

endpackage

### src/tccw_screen_mem.sv
// Screen cell store: one write port and one registered read port.
// Address is the physical row concatenated with the column index.
// Depends on tccw_pkg for the cell width.
module tccw_screen_mem import tccw_pkg::*; #(
  parameter  int unsigned DEPTH  = 3200,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [CELL_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [CELL_W-1:0] rdata_o
);

  logic [CELL_W-1:0] cells_q [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      cells_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= cells_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/tccw_ctrl.sv
// Console sequencer: cursor, row mapping, row-blank tracking and the result register.
// Drives the screen store ports and fills a blank row as its first character lands.
// Depends on tccw_pkg for the item, result, kind and state types.
module tccw_ctrl import tccw_pkg::*; #(
  parameter  int unsigned COLUMNS  = DEF_COLUMNS,
  parameter  int unsigned ROWS     = DEF_ROWS,
  parameter  int unsigned TAB_STEP = DEF_TAB_STEP,
  localparam int unsigned CIW      = $clog2(COLUMNS),
  localparam int unsigned RIW      = $clog2(ROWS),
  localparam int unsigned ADDR_W   = RIW + CIW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ATTR_W-1:0] attr_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  item_t             item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output result_t           result_o,
  output logic              mem_we_o,
  output logic [ADDR_W-1:0] mem_waddr_o,
  output logic [CELL_W-1:0] mem_wdata_o,
  output logic              mem_re_o,
  output logic [ADDR_W-1:0] mem_raddr_o,
  input  logic [CELL_W-1:0] mem_rdata_i
);

  localparam int unsigned      LocFullW = COL_W + ROW_W;
  localparam logic [RIW:0]     RowsExt  = (RIW+1)'(ROWS);
  localparam logic [RIW-1:0]   BaseLast = RIW'(ROWS - 1);
  localparam logic [CIW-1:0]   ColLast  = CIW'(COLUMNS - 1);
  localparam logic [COL_W:0]   ColLimit = (COL_W+1)'(COLUMNS);
  localparam logic [ROW_W:0]   RowLimit = (ROW_W+1)'(ROWS);
  localparam logic [ROW_W:0]   RowLast  = (ROW_W+1)'(ROWS - 1);
  localparam logic [COL_W:0]   TabExt   = (COL_W+1)'(TAB_STEP);

  // Logical row to physical row under the scroll offset.
  function automatic logic [RIW-1:0] to_phys(input logic [RIW-1:0] lrow,
                                             input logic [RIW-1:0] base);
    logic [RIW:0] sum;
    sum = {1'b0, lrow} + {1'b0, base};
    if (sum >= RowsExt) begin
      sum = sum - RowsExt;
    end
    return sum[RIW-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [COL_W-1:0]  cx_q, cx_d;
  logic [ROW_W-1:0]  cy_q, cy_d;
  logic [RIW-1:0]    base_q, base_d;
  logic [ROWS-1:0]   row_valid_q, row_valid_d;
  logic [CIW-1:0]    sweep_q, sweep_d;
  logic [RIW-1:0]    sw_row_q, sw_row_d;
  logic [CIW-1:0]    sw_col_q, sw_col_d;
  logic [CELL_W-1:0] sw_cell_q, sw_cell_d;
  logic              out_valid_q, out_valid_d;
  result_t           res_q, res_d;

  logic              accept;
  logic              on_screen;
  logic [RIW-1:0]    cur_phys;
  logic [RIW-1:0]    item_phys;
  logic              is_newline;
  logic              is_tab;
  logic              is_glyph;
  logic [COL_W:0]    x_adv;
  logic              line_brk;
  logic              last_row;
  logic [RIW-1:0]    base_next;
  logic              need_sweep;
  logic              read_hit;
  logic              sweep_last;
  logic              load_res;
  logic              err_now;
  logic [LocFullW-1:0] loc_full;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // Item decode against the current cursor and scroll offset.
  always_comb begin
    on_screen  = ({1'b0, item_i.column} < ColLimit) && ({1'b0, item_i.row} < RowLimit);
    cur_phys   = to_phys(cy_q[RIW-1:0], base_q);
    item_phys  = to_phys(item_i.row[RIW-1:0], base_q);
    is_newline = (item_i.char_code == CHAR_NEWLINE) && !item_i.raw_mode;
    is_tab     = (item_i.char_code == CHAR_TAB) && !item_i.raw_mode;
    is_glyph   = !is_newline && !is_tab;
    x_adv      = is_tab ? ({1'b0, cx_q} + TabExt) : ({1'b0, cx_q} + (COL_W+1)'(1));
    line_brk   = is_newline || (x_adv >= ColLimit);
    last_row   = ({1'b0, cy_q} == RowLast);
    base_next  = (base_q == BaseLast) ? '0 : base_q + RIW'(1);
    need_sweep = (item_i.kind == KIND_PUT) && is_glyph && !row_valid_q[cur_phys];
    read_hit   = (item_i.kind == KIND_READ) && on_screen && row_valid_q[item_phys];
    sweep_last = (sweep_q == ColLast);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && need_sweep) begin
          state_d = ST_SWEEP;
        end else if (accept && read_hit) begin
          state_d = ST_READ;
        end
      end
      ST_SWEEP: begin
        if (sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State outputs: store accesses and the result load strobe.
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = {cur_phys, cx_q[CIW-1:0]};
    mem_wdata_o = {attr_i, item_i.char_code};
    mem_re_o    = 1'b0;
    mem_raddr_o = {item_phys, item_i.column[CIW-1:0]};
    load_res    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        mem_we_o = accept && (item_i.kind == KIND_PUT) && is_glyph && !need_sweep;
        mem_re_o = accept && read_hit;
        load_res = accept && !need_sweep && !read_hit;
      end
      ST_SWEEP: begin
        // Blank the row, dropping the pending character in at its column.
        mem_we_o    = 1'b1;
        mem_waddr_o = {sw_row_q, sweep_q};
        mem_wdata_o = (sweep_q == sw_col_q) ? sw_cell_q : '0;
        load_res    = sweep_last;
      end
      ST_READ: begin
        load_res = 1'b1;
      end
      default: begin
        load_res = 1'b0;
      end
    endcase
  end

  // Cursor, scroll offset, row-blank flags and fill bookkeeping.
  always_comb begin
    cx_d        = cx_q;
    cy_d        = cy_q;
    base_d      = base_q;
    row_valid_d = row_valid_q;
    sweep_d     = (state_q == ST_SWEEP) ? sweep_q + CIW'(1) : '0;
    sw_row_d    = sw_row_q;
    sw_col_d    = sw_col_q;
    sw_cell_d   = sw_cell_q;
    err_now     = 1'b0;
    if (accept) begin
      unique case (item_i.kind)
        KIND_PUT: begin
          sw_row_d  = cur_phys;
          sw_col_d  = cx_q[CIW-1:0];
          sw_cell_d = {attr_i, item_i.char_code};
          if (line_brk) begin
            cx_d = '0;
            if (last_row) begin
              // Scroll: the old top row becomes the new, blank bottom row.
              base_d              = base_next;
              row_valid_d[base_q] = 1'b0;
            end else begin
              cy_d = cy_q + ROW_W'(1);
            end
          end else begin
            cx_d = x_adv[COL_W-1:0];
          end
        end
        KIND_SET: begin
          if (on_screen) begin
            cx_d = item_i.column;
            cy_d = item_i.row;
          end else begin
            err_now = 1'b1;
          end
        end
        KIND_CLEAR: begin
          cx_d        = '0;
          cy_d        = '0;
          row_valid_d = '0;
        end
        KIND_READ: begin
          err_now = !on_screen;
        end
        default: begin
          err_now = 1'b0;
        end
      endcase
    end
    if ((state_q == ST_SWEEP) && sweep_last) begin
      row_valid_d[sw_row_q] = 1'b1;
    end
  end

  // Result assembly from the cursor as it stands after the item.
  always_comb begin
    loc_full              = LocFullW'(cy_d) * LocFullW'(COLUMNS) + LocFullW'(cx_d);
    res_d.cursor_location = loc_full[LOC_W-1:0];
    res_d.cursor_column   = cx_d;
    res_d.cursor_row      = cy_d;
    res_d.read_data       = (state_q == ST_READ) ? mem_rdata_i : '0;
    res_d.position_error  = err_now;
    if (load_res) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cx_q        <= '0;
      cy_q        <= '0;
      base_q      <= '0;
      row_valid_q <= '0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      base_q      <= base_d;
      row_valid_q <= row_valid_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sw_row_q  <= sw_row_d;
    sw_col_q  <= sw_col_d;
    sw_cell_q <= sw_cell_d;
    if (load_res) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  // The cursor always lies on the screen.
  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cx_q} < ColLimit) && ({1'b0, cy_q} < RowLimit))
    else $error("cursor left the screen");

  // A read and a write never share a cycle on the store.
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o))
    else $error("store read and write in the same cycle");

  // A read request is followed by the data cycle with the result slot free.
  a_read_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re_o |=> (state_q == ST_READ) && !out_valid_q)
    else $error("read data landed on an occupied result slot");

  // A row fill ends by marking its row as written.
  a_fill_marks_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SWEEP) && sweep_last) |=> row_valid_q[$past(sw_row_q)])
    else $error("filled row not marked as written");

endmodule

### src/text_console_cell_writer.sv
// Text console cell writer top level: attribute register, stream packing and the core.
// Instantiates tccw_ctrl and tccw_screen_mem; depends on tccw_pkg.
//
// Channel   Dir  Beat contents (lowest bit first)
// s_axis    in   tuser: kind; tdata: char_code, raw_mode, column, row
// m_axis    out  tuser: position_error; tdata: cursor_location, cursor_column,
//                cursor_row, read_data
// cfg       in   cfg_wdata_i: text_attribute, written when cfg_we_i is high
//
// Set cursor, clear screen, off-screen or blank-row reads and puts that need no row fill load the result when taken.
// A read of a written row passes through ST_READ, as the store's read port is registered.
// The first character into a row left blank by reset, clear or scroll holds off new beats
// while the row is filled, one cell a cycle through the single write port.
// Reset marks every row blank at once, so no clearing pass follows it.
// While a result waits untaken in the output register, no new beat is taken.
module text_console_cell_writer import tccw_pkg::*; #(
  parameter int unsigned COLUMNS  = DEF_COLUMNS,
  parameter int unsigned ROWS     = DEF_ROWS,
  parameter int unsigned TAB_STEP = DEF_TAB_STEP
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [ATTR_W-1:0]    cfg_wdata_i,     // text_attribute
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,    // char_code, raw_mode, column, row
  input  logic [KIND_W-1:0]    s_axis_tuser,    // kind
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,    // cursor_location, cursor_column,
                                                // cursor_row, read_data
  output logic [0:0]           m_axis_tuser     // position_error
);

  localparam int unsigned CIW    = $clog2(COLUMNS);
  localparam int unsigned RIW    = $clog2(ROWS);
  localparam int unsigned ADDR_W = RIW + CIW;
  localparam int unsigned DEPTH  = ROWS << CIW;

  logic [ATTR_W-1:0] attr_q;
  item_t             item;
  result_t           result;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  // Attribute register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  // Unpack the input beat.
  always_comb begin
    item.kind      = kind_e'(s_axis_tuser);
    item.char_code = s_axis_tdata[7:0];
    item.raw_mode  = s_axis_tdata[8];
    item.column    = s_axis_tdata[15:9];
    item.row       = s_axis_tdata[20:16];
  end

  tccw_ctrl #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STEP (TAB_STEP)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .attr_i      (attr_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .item_i      (item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  tccw_screen_mem #(
    .DEPTH (DEPTH)
  ) u_screen_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Pack the output beat.
  assign m_axis_tdata = {1'b0, result.read_data, result.cursor_row, result.cursor_column,
                         result.cursor_location};
  assign m_axis_tuser = result.position_error;

endmodule
